@@ rtl/bbs_pkg.sv @@
// Shared types, codes and constants of the buzzer beep sequencer.
package bbs_pkg;

    localparam int TUNE_BITS_DEF = 32;
    localparam int TUNE_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 10;

    localparam logic [9:0] PWM_FULL_RST = 10'd1023;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_LED   = 2'd2;

    localparam logic [1:0] MODE_COUNTED = 2'd0;
    localparam logic [1:0] MODE_FOLLOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_INV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [14:0]       beep_count;
        logic [15:0]       on_ticks;
        logic [15:0]       off_ticks;
        logic [TUNE_W-1:0] tune_pattern;
        logic [1:0]        repeat_mode;
        logic              led_level;
    } t_in;

    typedef struct packed {
        logic       drive_valid;
        logic       pin_level;
        logic [8:0] pwm_duty;
        logic       busy_res;
    } t_out;

    typedef struct packed {
        logic       output_inverted;
        logic       frequency_mode;
        logic [9:0] pwm_full_range;
    } t_cfg;

endpackage

@@ rtl/bbs_tune_len.sv @@
// Tune length finder: position of the leading one within the stored tune bits, plus one.
module bbs_tune_len
    import bbs_pkg::*;
#(
    parameter int TUNE_BITS = TUNE_BITS_DEF,
    parameter int LEN_W     = $clog2(TUNE_BITS + 1)
) (
    input  logic [TUNE_BITS-1:0] i_tune,
    output logic [LEN_W-1:0]     o_len
);

    always_comb begin
        o_len = '0;
        for (int i = 0; i < TUNE_BITS; i++) begin
            if (i_tune[i]) begin
                o_len = LEN_W'(i + 1);
            end
        end
    end

endmodule

@@ rtl/bbs_seq_core.sv @@
// Sequencer state and the single-pass next-state and drive logic for one item.
module bbs_seq_core
    import bbs_pkg::*;
#(
    parameter int TUNE_BITS = TUNE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_res
);

    localparam int LEN_W = $clog2(TUNE_BITS + 1);
    localparam int IDX_W = $clog2(TUNE_BITS);
    localparam int EXT_W = (TUNE_BITS > TUNE_W) ? TUNE_BITS : TUNE_W;

    logic                 r_en, n_en;
    logic [1:0]           r_mode, n_mode;
    logic [15:0]          r_hbc, n_hbc;
    logic [15:0]          r_tl, n_tl;
    logic [15:0]          r_on, n_on;
    logic [15:0]          r_off, n_off;
    logic [LEN_W-1:0]     r_bl, n_bl;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [TUNE_BITS-1:0] r_tune, n_tune;
    logic                 r_tone, n_tone;
    logic                 r_last, n_last;

    logic [EXT_W-1:0]     tune_ext;
    logic [TUNE_BITS-1:0] tune_fit;
    logic [LEN_W-1:0]     tune_len;

    assign tune_ext = EXT_W'(i_item.tune_pattern);
    assign tune_fit = tune_ext[TUNE_BITS-1:0];

    bbs_tune_len #(
        .TUNE_BITS (TUNE_BITS),
        .LEN_W     (LEN_W)
    ) u_tune_len (
        .i_tune (tune_fit),
        .o_len  (tune_len)
    );

    always_comb begin
        logic        drv_req;
        logic        drv_lvl;
        logic        lv;
        logic        tone;
        logic [15:0] tl_dec;
        logic [15:0] hbc_dec;
        logic [LEN_W-1:0] bl_dec;

        n_en   = r_en;
        n_mode = r_mode;
        n_hbc  = r_hbc;
        n_tl   = r_tl;
        n_on   = r_on;
        n_off  = r_off;
        n_bl   = r_bl;
        n_len  = r_len;
        n_tune = r_tune;
        n_tone = r_tone;
        n_last = r_last;
        o_res  = '0;
        drv_req = 1'b0;
        drv_lvl = 1'b0;
        tone    = 1'b0;
        tl_dec  = '0;
        hbc_dec = '0;
        bl_dec  = '0;

        case (i_item.cmd)
            CMD_TICK: begin
                if (r_en && r_mode != MODE_FOLLOW) begin
                    if (r_hbc == 16'd0) begin
                        n_en = 1'b0;
                    end else begin
                        // A zero duration never reloads, so the step stays frozen.
                        if (r_tl != 16'd0) begin
                            tl_dec = r_tl - 16'd1;
                            n_tl   = tl_dec;
                            if (tl_dec == 16'd0) begin
                                if (r_bl != '0) begin
                                    bl_dec = r_bl - LEN_W'(1);
                                    n_bl   = bl_dec;
                                    // Tune plays from the leading one downwards.
                                    tone   = r_tune[bl_dec[IDX_W-1:0]];
                                end else begin
                                    n_bl    = r_len;
                                    hbc_dec = r_hbc - ((r_len != '0) ? 16'd2 : 16'd1);
                                    tone    = hbc_dec[0];
                                    n_hbc   = hbc_dec |
                                              ((r_mode != MODE_COUNTED) ? 16'd2 : 16'd0);
                                end
                                n_tone = tone;
                                n_tl   = tone ? r_on : r_off;
                            end
                        end
                        drv_req = 1'b1;
                        drv_lvl = n_tone;
                    end
                end
            end
            CMD_START: begin
                n_off  = i_item.off_ticks;
                n_on   = i_item.on_ticks;
                n_tl   = 16'd1;
                n_mode = i_item.repeat_mode;
                n_len  = tune_len;
                n_bl   = tune_len;
                n_tune = tune_fit;
                n_hbc  = {i_item.beep_count, 1'b0};
                n_en   = (i_item.beep_count != 15'd0);
                if (i_item.beep_count == 15'd0) begin
                    drv_req = 1'b1;
                    drv_lvl = 1'b0;
                end
            end
            CMD_LED: begin
                if (r_en && r_mode == MODE_FOLLOW) begin
                    n_tone  = i_item.led_level;
                    drv_req = 1'b1;
                    drv_lvl = i_item.led_level;
                end
            end
            default: begin
            end
        endcase

        lv = drv_lvl ^ i_cfg.output_inverted;
        if (drv_req) begin
            if (i_cfg.frequency_mode) begin
                // The PWM duty is only rewritten when the level changes.
                if (r_last != lv) begin
                    o_res.drive_valid = 1'b1;
                    o_res.pin_level   = lv;
                    o_res.pwm_duty    = lv ? i_cfg.pwm_full_range[9:1] : 9'd0;
                    n_last            = lv;
                end
            end else begin
                o_res.drive_valid = 1'b1;
                o_res.pin_level   = lv;
            end
        end
        o_res.busy_res = n_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_mode <= '0;
            r_hbc  <= '0;
            r_tl   <= '0;
            r_on   <= '0;
            r_off  <= '0;
            r_bl   <= '0;
            r_len  <= '0;
            r_tune <= '0;
            r_tone <= 1'b0;
            r_last <= 1'b0;
        end else if (i_step) begin
            r_en   <= n_en;
            r_mode <= n_mode;
            r_hbc  <= n_hbc;
            r_tl   <= n_tl;
            r_on   <= n_on;
            r_off  <= n_off;
            r_bl   <= n_bl;
            r_len  <= n_len;
            r_tune <= n_tune;
            r_tone <= n_tone;
            r_last <= n_last;
        end
    end

endmodule

@@ rtl/buzzer_beep_sequencer.sv @@
// An accepted item waits in the input register; its result is registered into the result register as it advances.
// Throughput: one item per cycle while results are taken; the input register feeds the sequencer in a single pass.
// The input register is freed whenever the result register is empty or being taken.
// Reset (synchronous, active low) clears the sequence state and empties both registers;
// configuration returns to non-inverted, digital mode and a full range of 1023.
// Top level of the buzzer beep sequencer: handshake registers and configuration.
module buzzer_beep_sequencer
    import bbs_pkg::*;
#(
    parameter int TUNE_BITS = TUNE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    t_cfg r_cfg;
    t_out core_res;
    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_inverted <= 1'b0;
            r_cfg.frequency_mode  <= 1'b0;
            r_cfg.pwm_full_range  <= PWM_FULL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OUT_INV:   r_cfg.output_inverted <= i_cfg_wdata[0];
                CFG_FREQ_MODE: r_cfg.frequency_mode  <= i_cfg_wdata[0];
                CFG_PWM_FULL:  r_cfg.pwm_full_range  <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    bbs_seq_core #(
        .TUNE_BITS (TUNE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

`ifndef NO_ASSERTIONS
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.drive_valid) |-> (!r_out.pin_level && r_out.pwm_duty == 9'd0))
        else $error("result without a write carries a level or duty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("registers not empty after reset");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held item did not reach the result register");
`endif

endmodule
